/* rtl/rasr_pkg.sv */
// Package: shared types and constants for the rational add/subtract reducer.
package rasr_pkg;

   localparam int unsigned IN_BITS = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_SUM,
      ST_GCD_START,
      ST_GCD_WAIT,
      ST_QN_START,
      ST_QN_WAIT,
      ST_QD_START,
      ST_QD_WAIT,
      ST_DONE
   } state_type;

endpackage

/* rtl/rasr_if.sv */
// Interfaces: valid/ready request and response channels.
interface rasr_req_if;
   import rasr_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic signed [IN_BITS-1:0]  first_numerator;
   logic signed [IN_BITS-1:0]  first_denominator;
   logic signed [IN_BITS-1:0]  second_numerator;
   logic signed [IN_BITS-1:0]  second_denominator;
   modport source (output valid, op, first_numerator, first_denominator,
                   second_numerator, second_denominator, input ready);
   modport sink (input valid, op, first_numerator, first_denominator,
                 second_numerator, second_denominator, output ready);
endinterface

interface rasr_rsp_if;
   import rasr_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [IN_BITS-1:0]  result_numerator;
   logic signed [IN_BITS-1:0]  result_denominator;
   logic                       fractions_equal;
   logic                       error_flag;
   modport source (output valid, result_numerator, result_denominator,
                   fractions_equal, error_flag, input ready);
   modport sink (input valid, result_numerator, result_denominator,
                 fractions_equal, error_flag, output ready);
endinterface

/* rtl/rasr_divider.sv */
// Divider: radix-2 restoring signed divider, truncating quotient and remainder.
module rasr_divider
   import rasr_pkg::*;
#(
   parameter int unsigned W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   localparam int unsigned CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [W-1:0]  q_ff, q_in;
   logic [W:0]    r_ff, r_in;
   logic [W-1:0]  d_ff, d_in;
   logic          qneg_ff, qneg_in;
   logic          rneg_ff, rneg_in;
   logic [W:0]    trial;
   logic [W:0]    shifted;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      d_in     = d_ff;
      qneg_in  = qneg_ff;
      rneg_in  = rneg_ff;
      shifted  = {r_ff[W-1:0], q_ff[W-1]};
      trial    = shifted - {1'b0, d_ff};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CW'(W);
         q_in     = dividend[W-1] ? (~dividend + 1'b1) : dividend;
         d_in     = divisor[W-1] ? (~divisor + 1'b1) : divisor;
         r_in     = '0;
         qneg_in  = dividend[W-1] ^ divisor[W-1];
         rneg_in  = dividend[W-1];
      end else if (busy_ff) begin
         if (trial[W]) begin
            r_in = shifted;
            q_in = {q_ff[W-2:0], 1'b0};
         end else begin
            r_in = trial;
            q_in = {q_ff[W-2:0], 1'b1};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      q_ff    <= q_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
   end

   assign done      = done_ff;
   assign quotient  = qneg_ff ? (~q_ff + 1'b1) : q_ff;
   assign remainder = rneg_ff ? (~r_ff[W-1:0] + 1'b1) : r_ff[W-1:0];

   assert property (@(posedge clock) disable iff (reset) done |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset)
                    busy_ff && !start |=> count_ff == $past(count_ff) - 1'b1 || done)
      else $error("divider count skipped");
   assert property (@(posedge clock) disable iff (reset) done |=> !done || $past(start, 2))
      else $error("divider done repeated");
endmodule

/* rtl/rational_add_sub_reduce_top.sv */
// Top level: rational add/subtract with Euclid reduction on one shared divider.
// Usage: present two fractions and op on the req_ channel (valid/ready).
// The transfer happens at a rising edge with req_valid and req_ready high.
// req_ready is high only while the block is idle; one item is in work at a time.
// The cross products and the common denominator use one shared multiplier in
// states MUL1, MUL2 and MUL3, then SUM forms the sum or difference. The gcd
// runs Euclid on one radix-2 divider; the two final quotients use the same divider.
// The result waits in an output register with rsp_valid high until
// rsp_ready takes it. A new item is taken while a result waits; when the
// receiver stalls, the next result holds in the last state until the
// register frees, and req_ready stays low meanwhile.
// Reset (synchronous, active high) drops any item in work and clears valid.
// On an error both result parts are zero and error_flag is set.
module rational_add_sub_reduce_top
   import rasr_pkg::*;
#(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   rasr_req_if.sink   req,
   rasr_rsp_if.source rsp
);
   localparam int unsigned W = WORD_BITS;

   state_type state_ff, state_in;

   logic [W-1:0] n1_ff, n1_in, d1_ff, d1_in, n2_ff, n2_in, d2_ff, d2_in;
   logic         op_ff, op_in;
   logic [W-1:0] p1_ff, p1_in, p2_ff, p2_in, den_ff, den_in, num_ff, num_in;
   logic [W-1:0] a_ff, a_in, b_ff, b_in, rn_ff, rn_in;
   logic         err_ff, err_in;
   logic         out_valid_ff, out_valid_in;
   logic [IN_BITS-1:0] out_num_ff, out_num_in, out_den_ff, out_den_in;
   logic         out_eq_ff, out_eq_in, out_err_ff, out_err_in;

   logic [W-1:0] mul_a, mul_b, mul_p;
   logic         div_start, div_done;
   logic [W-1:0] div_a, div_b, div_q, div_r;

   function automatic logic [W-1:0] in_w(input logic [IN_BITS-1:0] v);
      logic [W+IN_BITS-1:0] e;
      e = {{W{v[IN_BITS-1]}}, v};
      return e[W-1:0];
   endfunction

   function automatic logic [IN_BITS-1:0] out_w(input logic [W-1:0] v);
      logic [W+IN_BITS-1:0] e;
      e = {{IN_BITS{v[W-1]}}, v};
      return e[IN_BITS-1:0];
   endfunction

   assign mul_p = W'(mul_a * mul_b);

   rasr_divider #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      state_in     = state_ff;
      {n1_in, d1_in, n2_in, d2_in, op_in} = {n1_ff, d1_ff, n2_ff, d2_ff, op_ff};
      {p1_in, p2_in, den_in, num_in} = {p1_ff, p2_ff, den_ff, num_ff};
      {a_in, b_in, rn_in, err_in} = {a_ff, b_ff, rn_ff, err_ff};
      out_valid_in = out_valid_ff && !rsp.ready;
      {out_num_in, out_den_in, out_eq_in, out_err_in} =
         {out_num_ff, out_den_ff, out_eq_ff, out_err_ff};
      mul_a     = n1_ff;
      mul_b     = d2_ff;
      div_start = 1'b0;
      div_a     = a_ff;
      div_b     = b_ff;
      req.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               n1_in = in_w(req.first_numerator);
               d1_in = in_w(req.first_denominator);
               n2_in = in_w(req.second_numerator);
               d2_in = in_w(req.second_denominator);
               op_in = req.op;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            p1_in = mul_p;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mul_a = n2_ff;
            mul_b = d1_ff;
            p2_in = mul_p;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            mul_a = d1_ff;
            mul_b = d2_ff;
            den_in = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            num_in = op_ff ? (p1_ff - p2_ff) : (p1_ff + p2_ff);
            a_in   = num_in;
            b_in   = den_ff;
            err_in = (d1_ff == '0) || (d2_ff == '0) || (den_ff == '0);
            state_in = ST_GCD_START;
         end
         ST_GCD_START: begin
            if (b_ff == '0) begin
               if (a_ff == '0 || err_ff) begin
                  err_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_QN_START;
               end
            end else begin
               div_start = 1'b1;
               state_in = ST_GCD_WAIT;
            end
         end
         ST_GCD_WAIT: begin
            if (div_done) begin
               a_in = b_ff;
               b_in = div_r;
               state_in = ST_GCD_START;
            end
         end
         ST_QN_START: begin
            div_a = num_ff;
            div_b = a_ff;
            div_start = 1'b1;
            state_in = ST_QN_WAIT;
         end
         ST_QN_WAIT: begin
            if (div_done) begin
               rn_in = div_q;
               state_in = ST_QD_START;
            end
         end
         ST_QD_START: begin
            div_a = den_ff;
            div_b = a_ff;
            div_start = 1'b1;
            state_in = ST_QD_WAIT;
         end
         ST_QD_WAIT: begin
            if (div_done) begin
               b_in = div_q;
               if (div_q == '0) err_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               out_num_in = err_ff ? '0 : out_w(rn_ff);
               out_den_in = err_ff ? '0 : out_w(b_ff);
               out_eq_in  = (p1_ff == p2_ff);
               out_err_in = err_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      {n1_ff, d1_ff, n2_ff, d2_ff, op_ff} <= {n1_in, d1_in, n2_in, d2_in, op_in};
      {p1_ff, p2_ff, den_ff, num_ff} <= {p1_in, p2_in, den_in, num_in};
      {a_ff, b_ff, rn_ff, err_ff} <= {a_in, b_in, rn_in, err_in};
      {out_num_ff, out_den_ff, out_eq_ff, out_err_ff} <=
         {out_num_in, out_den_in, out_eq_in, out_err_in};
   end

   assign rsp.valid              = out_valid_ff;
   assign rsp.result_numerator   = out_num_ff;
   assign rsp.result_denominator = out_den_ff;
   assign rsp.fractions_equal    = out_eq_ff;
   assign rsp.error_flag         = out_err_ff;

   assert property (@(posedge clock) disable iff (reset)
                    rsp.valid && rsp.error_flag |->
                    rsp.result_numerator == '0 && rsp.result_denominator == '0)
      else $error("error result not zeroed");
   assert property (@(posedge clock) disable iff (reset)
                    req.valid && req.ready |=> state_ff == ST_MUL1)
      else $error("transfer did not start work");
   assert property (@(posedge clock) disable iff (reset)
                    rsp.valid && !rsp.ready |=> rsp.valid)
      else $error("result dropped under stall");
   assert property (@(posedge clock) disable iff (reset)
                    state_ff != ST_IDLE |-> !req.ready)
      else $error("ready outside idle");
endmodule
